@@ rtl/mcmd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcmd_pkg
// Shared types and codes for the MIDI channel message decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmd_pkg;

    localparam int NUM_CHAN   = 16;
    localparam int CHAN_W     = 4;
    localparam int DATA_W     = 7;
    localparam int PNUM_W     = 14;
    localparam int VALUE_W    = 14;
    localparam int LEN_W      = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // status byte upper nibble
    localparam logic [3:0] MSG_NOTE_OFF  = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON   = 4'h9;
    localparam logic [3:0] MSG_POLY_AT   = 4'hA;
    localparam logic [3:0] MSG_CTRL      = 4'hB;
    localparam logic [3:0] MSG_PROGRAM   = 4'hC;
    localparam logic [3:0] MSG_CHAN_AT   = 4'hD;
    localparam logic [3:0] MSG_BEND      = 4'hE;

    // message lengths
    localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    // controller numbers
    localparam logic [DATA_W-1:0] CC_DATA_MSB   = 7'd6;
    localparam logic [DATA_W-1:0] CC_DATA_LSB   = 7'd38;
    localparam logic [DATA_W-1:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [DATA_W-1:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [DATA_W-1:0] CC_RPN_LSB    = 7'd100;
    localparam logic [DATA_W-1:0] CC_RPN_MSB    = 7'd101;
    localparam logic [DATA_W-1:0] CC_RESET_LO   = 7'd120;
    localparam logic [DATA_W-1:0] CC_RESET_HI   = 7'd123;

    typedef enum logic [3:0] {
        KIND_NOTE_OFF = 4'd0,
        KIND_NOTE_ON  = 4'd1,
        KIND_POLY_AT  = 4'd2,
        KIND_CTRL     = 4'd3,
        KIND_PROGRAM  = 4'd4,
        KIND_CHAN_AT  = 4'd5,
        KIND_BEND     = 4'd6,
        KIND_RPN      = 4'd7,
        KIND_NRPN     = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAN_W-1:0]   chan;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   low;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } evt_t;

    // per-channel parameter selection
    typedef struct packed {
        logic               rpn_active;
        logic [PNUM_W-1:0]  rpn_number;
        logic               nrpn_active;
        logic [PNUM_W-1:0]  nrpn_number;
    } pentry_t;

    typedef struct packed {
        logic    we;
        pentry_t entry;
    } pupd_t;

endpackage

`default_nettype wire

@@ rtl/mcmd_param_table.sv @@
// ----------------------------------------------------------------------------
// mcmd_param_table
// Per-channel RPN/NRPN selection registers, one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmd_param_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [mcmd_pkg::CHAN_W-1:0]   chan,
    input  wire logic                          wr_en,
    input  wire mcmd_pkg::pentry_t             wr_entry,
    output mcmd_pkg::pentry_t                  rd_entry
);

    mcmd_pkg::pentry_t entry_reg [mcmd_pkg::NUM_CHAN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mcmd_pkg::NUM_CHAN; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr_en) begin
            entry_reg[chan] <= wr_entry;
        end
    end

    assign rd_entry = entry_reg[chan];

endmodule

`default_nettype wire

@@ rtl/mcmd_decode.sv @@
// ----------------------------------------------------------------------------
// mcmd_decode
// Turns one channel message into up to two events plus a table update.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmd_decode (
    input  wire logic [7:0]                   status_byte,
    input  wire logic [mcmd_pkg::DATA_W-1:0]  data_one,
    input  wire logic [mcmd_pkg::DATA_W-1:0]  data_two,
    input  wire logic [mcmd_pkg::LEN_W-1:0]   msg_length,
    input  wire mcmd_pkg::pentry_t            cur_entry,
    output logic [1:0]                        evt_count,
    output mcmd_pkg::evt_t                    evt0,
    output mcmd_pkg::evt_t                    evt1,
    output mcmd_pkg::pupd_t                   upd
);

    logic [3:0]                     msg_type;
    logic [mcmd_pkg::CHAN_W-1:0]    ch;
    logic                           full3;
    logic                           full2;
    logic [mcmd_pkg::VALUE_W-1:0]   entry_val;

    assign msg_type = status_byte[7:4];
    assign ch       = status_byte[3:0];
    assign full3    = (msg_length == mcmd_pkg::LEN_THREE);
    assign full2    = (msg_length >= mcmd_pkg::LEN_TWO);
    // data entry MSB lands in the upper seven bits
    assign entry_val = (data_one == mcmd_pkg::CC_DATA_MSB)
                     ? {data_two, 7'd0} : {7'd0, data_two};

    always_comb begin
        evt_count   = 2'd0;
        evt0.kind   = mcmd_pkg::KIND_NOTE_OFF;
        evt0.chan   = ch;
        evt0.key    = data_one;
        evt0.low    = '0;
        evt0.value  = '0;
        evt0.last   = 1'b0;
        evt1.kind   = mcmd_pkg::KIND_RPN;
        evt1.chan   = ch;
        evt1.key    = cur_entry.rpn_number[13:7];
        evt1.low    = cur_entry.rpn_number[6:0];
        evt1.value  = entry_val;
        evt1.last   = 1'b1;
        upd.we      = 1'b0;
        upd.entry   = cur_entry;

        unique case (msg_type)
            mcmd_pkg::MSG_NOTE_OFF: begin
                if (full3) evt_count = 2'd1;
            end
            mcmd_pkg::MSG_NOTE_ON: begin
                if (full3) evt_count = 2'd1;
                if (data_two != '0) begin
                    evt0.kind  = mcmd_pkg::KIND_NOTE_ON;
                    evt0.value = {7'd0, data_two};
                end
            end
            mcmd_pkg::MSG_POLY_AT: begin
                if (full3) evt_count = 2'd1;
                evt0.kind  = mcmd_pkg::KIND_POLY_AT;
                evt0.value = {7'd0, data_two};
            end
            mcmd_pkg::MSG_CTRL: begin
                evt0.kind  = mcmd_pkg::KIND_CTRL;
                evt0.value = {7'd0, data_two};
                if (full3) begin
                    evt_count = 2'd1;
                    if (data_one == mcmd_pkg::CC_DATA_MSB ||
                        data_one == mcmd_pkg::CC_DATA_LSB) begin
                        if (cur_entry.rpn_active) begin
                            evt_count = 2'd2;
                        end else if (cur_entry.nrpn_active) begin
                            evt_count = 2'd2;
                            evt1.kind = mcmd_pkg::KIND_NRPN;
                            evt1.key  = cur_entry.nrpn_number[13:7];
                            evt1.low  = cur_entry.nrpn_number[6:0];
                        end
                    end else if (data_one == mcmd_pkg::CC_NRPN_LSB ||
                                 data_one == mcmd_pkg::CC_NRPN_MSB) begin
                        upd.we = 1'b1;
                        if (!cur_entry.nrpn_active) upd.entry.nrpn_number = '0;
                        upd.entry.nrpn_active = 1'b1;
                        upd.entry.rpn_active  = 1'b0;
                        if (data_one == mcmd_pkg::CC_NRPN_LSB)
                            upd.entry.nrpn_number[6:0] = data_two;
                        else
                            upd.entry.nrpn_number[13:7] = data_two;
                    end else if (data_one == mcmd_pkg::CC_RPN_LSB ||
                                 data_one == mcmd_pkg::CC_RPN_MSB) begin
                        upd.we = 1'b1;
                        if (!cur_entry.rpn_active) upd.entry.rpn_number = '0;
                        upd.entry.rpn_active  = 1'b1;
                        upd.entry.nrpn_active = 1'b0;
                        if (data_one == mcmd_pkg::CC_RPN_LSB)
                            upd.entry.rpn_number[6:0] = data_two;
                        else
                            upd.entry.rpn_number[13:7] = data_two;
                    end else if (data_one >= mcmd_pkg::CC_RESET_LO &&
                                 data_one <= mcmd_pkg::CC_RESET_HI) begin
                        upd.we = 1'b1;
                        upd.entry.rpn_active  = 1'b0;
                        upd.entry.nrpn_active = 1'b0;
                    end
                end
            end
            mcmd_pkg::MSG_PROGRAM: begin
                if (full2) evt_count = 2'd1;
                evt0.kind = mcmd_pkg::KIND_PROGRAM;
            end
            mcmd_pkg::MSG_CHAN_AT: begin
                if (full2) evt_count = 2'd1;
                evt0.kind  = mcmd_pkg::KIND_CHAN_AT;
                evt0.key   = '0;
                evt0.value = {7'd0, data_one};
            end
            mcmd_pkg::MSG_BEND: begin
                if (full3) evt_count = 2'd1;
                evt0.kind  = mcmd_pkg::KIND_BEND;
                evt0.key   = '0;
                evt0.value = {data_two, data_one};
            end
            default: begin
                evt_count = 2'd0;
            end
        endcase

        evt0.last = (evt_count == 2'd1);
    end

endmodule

`default_nettype wire

@@ rtl/midi_channel_message_decoder.sv @@
// ----------------------------------------------------------------------------
// midi_channel_message_decoder
// Framed MIDI channel message in, typed events out, with RPN/NRPN tracking.
// ----------------------------------------------------------------------------
// One input beat carries one channel message (status, two data bytes, length).
// Each message gives zero, one or two output beats; m_tlast marks the final
// beat of a message. A beat is taken in every cycle as long as the two-entry
// result queue can hold its events, so single-event messages stream at one
// beat per cycle, held first in the input register and then in the queue.
// A data-entry control change (controller 6 or 38) with an RPN or NRPN
// selected gives the control change beat and then the RPN/NRPN beat; the
// drain of the result queue paces such messages. The per-channel parameter
// selection is reset to nothing selected by aresetn.
`default_nettype none

module midi_channel_message_decoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: status_byte[7:0], data_one[14:8], data_two[21:15], msg_length[23:22]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mcmd_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: event_kind[3:0], chan_num[7:4], key_number[14:8], param_low[21:15],
    //          event_value[35:22], zero[39:36]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mcmd_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast
);

    // input register
    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [mcmd_pkg::S_TDATA_W-1:0]     in_data_reg;

    // two-entry result queue; res0 is the head
    mcmd_pkg::evt_t                     res0_reg, res0_next;
    mcmd_pkg::evt_t                     res1_reg, res1_next;
    logic [1:0]                         cnt_reg, cnt_next;

    logic [1:0]                         evt_count;
    mcmd_pkg::evt_t                     evt0, evt1;
    mcmd_pkg::pupd_t                    upd;
    mcmd_pkg::pentry_t                  cur_entry;

    logic                               pop;
    logic [1:0]                         rem;
    logic [1:0]                         load;
    logic                               fits;
    logic                               in_adv;
    mcmd_pkg::evt_t                     head;

    mcmd_param_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .chan     (in_data_reg[3:0]),
        .wr_en    (in_adv && upd.we),
        .wr_entry (upd.entry),
        .rd_entry (cur_entry)
    );

    mcmd_decode u_decode (
        .status_byte (in_data_reg[7:0]),
        .data_one    (in_data_reg[14:8]),
        .data_two    (in_data_reg[21:15]),
        .msg_length  (in_data_reg[23:22]),
        .cur_entry   (cur_entry),
        .evt_count   (evt_count),
        .evt0        (evt0),
        .evt1        (evt1),
        .upd         (upd)
    );

    assign pop    = m_tvalid && m_tready;
    assign rem    = cnt_reg - {1'b0, pop};
    // the held message moves on once the queue has room for all its events
    assign fits   = ({1'b0, rem} + {1'b0, evt_count}) <= 3'd2;
    assign in_adv = in_valid_reg && fits;
    assign load   = in_adv ? evt_count : 2'd0;
    assign head   = pop ? res1_reg : res0_reg;

    assign s_tready = !in_valid_reg || fits;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_comb begin
        cnt_next  = rem + load;
        res0_next = res0_reg;
        res1_next = res1_reg;
        unique case (rem)
            2'd0: begin
                res0_next = evt0;
                res1_next = evt1;
            end
            2'd1: begin
                res0_next = head;
                res1_next = evt0;
            end
            default: begin
                res0_next = res0_reg;
                res1_next = res1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_data_reg <= s_tdata;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'd0, res0_reg.value, res0_reg.low, res0_reg.key,
                       res0_reg.chan, res0_reg.kind};
    assign m_tlast  = res0_reg.last;

    // queue never holds more than two beats
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // a second queued beat always closes its message
    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> res1_reg.last)
        else $error("second queued beat without last");

    // stalling the input only happens with a message held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled while empty");

    // a held message that cannot move leaves the queue occupied next cycle
    a_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fits) |=> (cnt_reg != 2'd0))
        else $error("queue empty after blocked message");

endmodule

`default_nettype wire
